// File: rtl/iamk_pkg.sv
package iamk_pkg;

  // One tick of paddle contacts.
  typedef struct packed {
    logic left_contact;
    logic right_contact;
  } iamk_in_t;

  // One result per tick.
  typedef struct packed {
    logic       key_level;
    logic       char_ready;
    logic [6:0] char_ascii;
    logic [7:0] element_pattern;
  } iamk_out_t;

  // Settings passed from the register block to the keyer core.
  typedef struct packed {
    logic [10:0] dit_ticks;
    logic        swap_paddles;
    logic        mode_b;
  } iamk_cfg_t;

  // Register map: index is the byte address divided by four.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_DIT_TICKS    = 2'd0,
    REG_SWAP_PADDLES = 2'd1,
    REG_MODE_B       = 2'd2
  } iamk_reg_t;

  localparam logic [10:0] DIT_TICKS_RESET = 11'd60;

  // Stable keyer phases, one-hot. The checking phases and the key-down
  // preparation never last beyond a tick and so have no code of their own.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_KEYED    = 4'b0010,
    PH_GAP      = 4'b0100,
    PH_PRE_IDLE = 4'b1000
  } iamk_phase_t;

  // Element pattern starts as a single zero under a pad of ones.
  localparam logic [7:0] PATTERN_START = 8'hFE;
  localparam logic [6:0] ASCII_SPACE   = 7'h20;

  // Morse table: padded pattern (dit 0, dah 1) to ASCII.
  function automatic logic [6:0] decode_pattern(input logic [7:0] pat);
    logic [6:0] ch;
    case (pat)
      8'hF9:   ch = 7'h41; // A
      8'hE8:   ch = 7'h42; // B
      8'hEA:   ch = 7'h43; // C
      8'hF4:   ch = 7'h44; // D
      8'hFC:   ch = 7'h45; // E
      8'hE2:   ch = 7'h46; // F
      8'hF6:   ch = 7'h47; // G
      8'hE0:   ch = 7'h48; // H
      8'hF8:   ch = 7'h49; // I
      8'hE7:   ch = 7'h4A; // J
      8'hF5:   ch = 7'h4B; // K
      8'hE4:   ch = 7'h4C; // L
      8'hFB:   ch = 7'h4D; // M
      8'hFA:   ch = 7'h4E; // N
      8'hF7:   ch = 7'h4F; // O
      8'hE6:   ch = 7'h50; // P
      8'hED:   ch = 7'h51; // Q
      8'hF2:   ch = 7'h52; // R
      8'hF0:   ch = 7'h53; // S
      8'hFD:   ch = 7'h54; // T
      8'hF1:   ch = 7'h55; // U
      8'hE1:   ch = 7'h56; // V
      8'hF3:   ch = 7'h57; // W
      8'hE9:   ch = 7'h58; // X
      8'hEB:   ch = 7'h59; // Y
      8'hEC:   ch = 7'h5A; // Z
      8'hDF:   ch = 7'h30; // 0
      8'hCF:   ch = 7'h31; // 1
      8'hC7:   ch = 7'h32; // 2
      8'hC3:   ch = 7'h33; // 3
      8'hC1:   ch = 7'h34; // 4
      8'hC0:   ch = 7'h35; // 5
      8'hD0:   ch = 7'h36; // 6
      8'hD8:   ch = 7'h37; // 7
      8'hDC:   ch = 7'h38; // 8
      8'hDE:   ch = 7'h39; // 9
      8'hD2:   ch = 7'h2F; // slash
      8'h8C:   ch = 7'h3F; // question mark
      8'hCA:   ch = 7'h2A; // asterisk
      8'h00:   ch = 7'h23; // hash
      default: ch = ASCII_SPACE;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/iamk_cfg.sv
module iamk_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [iamk_pkg::ADDR_W-1:0]  paddr,
  input  logic [iamk_pkg::DATA_W-1:0]  pwdata,
  output logic [iamk_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output iamk_pkg::iamk_cfg_t          cfg
);
  import iamk_pkg::*;

  logic [10:0] dit_ticks_r;
  logic        swap_paddles_r;
  logic        mode_b_r;
  logic        wr_en;
  iamk_reg_t   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = iamk_reg_t'(paddr[3:2]);

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dit_ticks_r    <= DIT_TICKS_RESET;
      swap_paddles_r <= 1'b0;
      mode_b_r       <= 1'b1;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DIT_TICKS:    dit_ticks_r    <= pwdata[10:0];
        REG_SWAP_PADDLES: swap_paddles_r <= pwdata[0];
        REG_MODE_B:       mode_b_r       <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_sel)
      REG_DIT_TICKS:    prdata = DATA_W'(dit_ticks_r);
      REG_SWAP_PADDLES: prdata = DATA_W'(swap_paddles_r);
      REG_MODE_B:       prdata = DATA_W'(mode_b_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg = '{dit_ticks: dit_ticks_r, swap_paddles: swap_paddles_r, mode_b: mode_b_r};

endmodule

// File: rtl/iamk_core.sv
module iamk_core #(
  parameter int unsigned TIMER_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  iamk_pkg::iamk_in_t   contacts,
  input  iamk_pkg::iamk_cfg_t  cfg,
  output iamk_pkg::iamk_out_t  result
);
  import iamk_pkg::*;

  // Durations are worked out at 13 bits (three dits of the longest setting)
  // or at the timer width, whichever is larger.
  localparam int unsigned DUR_W = 13;
  localparam int unsigned CMP_W = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;
  localparam logic [CMP_W-1:0] LIM_MAX = CMP_W'((64'd1 << TIMER_BITS) - 64'd2);

  iamk_phase_t           phase_r,  phase_nxt;
  logic                  dit_latch_r, dit_latch_nxt;
  logic                  dah_latch_r, dah_latch_nxt;
  logic                  dip_r,    dip_nxt;
  logic [TIMER_BITS-1:0] cnt_r,    cnt_nxt;
  logic [TIMER_BITS-1:0] lim_r,    lim_nxt;
  logic [7:0]            pat_r,    pat_nxt;
  logic                  key_r,    key_nxt;

  logic                  dit_pad, dah_pad, dit_or, dah_or;
  logic [TIMER_BITS-1:0] cnt_inc;
  logic                  done;
  logic [CMP_W-1:0]      dur1, dur2, dur3;
  logic [TIMER_BITS-1:0] lim1, lim2, lim3;
  logic                  kd_go, kd_dit, ready;
  logic [7:0]            kd_base;

  // Paddle mapping and latches merged with the current contacts.
  assign dit_pad = cfg.swap_paddles ? contacts.right_contact : contacts.left_contact;
  assign dah_pad = cfg.swap_paddles ? contacts.left_contact  : contacts.right_contact;
  assign dit_or  = dit_latch_r | dit_pad;
  assign dah_or  = dah_latch_r | dah_pad;

  // Interval counter advances once per tick and sticks at all ones.
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign done    = cnt_inc > lim_r;

  // Timer durations, held below the counter's top value so they expire.
  assign dur1 = CMP_W'(cfg.dit_ticks);
  assign dur2 = CMP_W'({cfg.dit_ticks, 1'b0});
  assign dur3 = dur1 + dur2;
  assign lim1 = (dur1 > LIM_MAX) ? LIM_MAX[TIMER_BITS-1:0] : dur1[TIMER_BITS-1:0];
  assign lim2 = (dur2 > LIM_MAX) ? LIM_MAX[TIMER_BITS-1:0] : dur2[TIMER_BITS-1:0];
  assign lim3 = (dur3 > LIM_MAX) ? LIM_MAX[TIMER_BITS-1:0] : dur3[TIMER_BITS-1:0];

  // The whole chain of phase changes that one tick can make, folded from
  // each stable phase. Any path that reaches the dit or dah check with a
  // latch set ends in a new element, which the tail of this block applies.
  always_comb begin
    phase_nxt     = phase_r;
    dit_latch_nxt = dit_latch_r;
    dah_latch_nxt = dah_latch_r;
    dip_nxt       = dip_r;
    cnt_nxt       = cnt_inc;
    lim_nxt       = lim_r;
    pat_nxt       = pat_r;
    key_nxt       = key_r;
    kd_go         = 1'b0;
    kd_dit        = 1'b0;
    kd_base       = pat_r;
    ready         = 1'b0;

    case (phase_r)
      PH_KEYED: begin
        if (done) begin
          // Key up and start the element gap; the gap samples the paddles.
          key_nxt       = 1'b0;
          phase_nxt     = PH_GAP;
          cnt_nxt       = '0;
          lim_nxt       = lim1;
          dit_latch_nxt = dit_or;
          dah_latch_nxt = dah_or;
        end else if (cfg.mode_b) begin
          dit_latch_nxt = dit_or;
          dah_latch_nxt = dah_or;
        end
      end
      PH_GAP: begin
        dit_latch_nxt = dit_or;
        dah_latch_nxt = dah_or;
        if (done) begin
          if (dip_r) begin
            // After a dit the dah latch is checked first.
            dip_nxt       = 1'b0;
            dit_latch_nxt = 1'b0;
            if (dah_or) begin
              kd_go = 1'b1;
            end else if (dit_pad) begin
              kd_go  = 1'b1;
              kd_dit = 1'b1;
            end else begin
              phase_nxt = PH_PRE_IDLE;
              cnt_nxt   = '0;
              lim_nxt   = lim2;
            end
          end else begin
            dah_latch_nxt = 1'b0;
            if (dit_or || dah_pad) begin
              kd_go  = 1'b1;
              kd_dit = dit_or;
            end else begin
              phase_nxt = PH_PRE_IDLE;
              cnt_nxt   = '0;
              lim_nxt   = lim2;
            end
          end
        end
      end
      PH_PRE_IDLE: begin
        if (dit_or || dah_or) begin
          kd_go  = 1'b1;
          kd_dit = dit_or;
        end else if (done) begin
          // Character gap over: report the pattern.
          ready     = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        if (dit_or || dah_or) begin
          kd_go   = 1'b1;
          kd_dit  = dit_or;
          kd_base = PATTERN_START;
        end
      end
    endcase

    // Start a new element: shift it in, load its timer, key down.
    if (kd_go) begin
      key_nxt       = 1'b1;
      dit_latch_nxt = 1'b0;
      dah_latch_nxt = 1'b0;
      phase_nxt     = PH_KEYED;
      cnt_nxt       = '0;
      if (kd_dit) begin
        dip_nxt = 1'b1;
        lim_nxt = lim1;
        pat_nxt = {kd_base[6:0], 1'b0};
      end else begin
        lim_nxt = lim3;
        pat_nxt = {kd_base[6:0], 1'b1};
      end
    end
  end

  // Keyer state advances once per processed tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      dit_latch_r <= 1'b0;
      dah_latch_r <= 1'b0;
      dip_r       <= 1'b0;
      cnt_r       <= '0;
      lim_r       <= '0;
      pat_r       <= PATTERN_START;
      key_r       <= 1'b0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      dit_latch_r <= dit_latch_nxt;
      dah_latch_r <= dah_latch_nxt;
      dip_r       <= dip_nxt;
      cnt_r       <= cnt_nxt;
      lim_r       <= lim_nxt;
      pat_r       <= pat_nxt;
      key_r       <= key_nxt;
    end
  end

  // Character fields read as zero unless a character completes.
  assign result = '{key_level:       key_nxt,
                    char_ready:      ready,
                    char_ascii:      ready ? decode_pattern(pat_r) : 7'd0,
                    element_pattern: ready ? pat_r : 8'd0};

endmodule

// File: rtl/iamk_out_buf.sv
module iamk_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  iamk_pkg::iamk_out_t  push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iamk_pkg::iamk_out_t  out_data
);
  import iamk_pkg::*;

  logic      head_valid_r;
  logic      skid_valid_r;
  iamk_out_t head_r;
  iamk_out_t skid_r;
  logic      pop;

  assign pop       = head_valid_r & ~out_stall;
  assign full      = skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

  // Control: head register shown on the port, skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!head_valid_r || pop) begin
      head_valid_r <= skid_valid_r | push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: no push arrives while the skid entry is occupied.
  always_ff @(posedge clk) begin
    if (!head_valid_r || pop) begin
      head_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// File: rtl/iambic_morse_keyer_top.sv
// Channel   Direction  Handshake                 Payload
// in_       input      in_valid / in_stall       iamk_in_t  (paddle contacts of one tick)
// out_      output     out_valid / out_stall     iamk_out_t (key level, character)
// config    input      psel penable pwrite pready 32-bit data, registers at 0x0, 0x4, 0x8
//
// One tick is accepted per cycle while in_stall is low; each tick and its result
// pass through the input register and then the output register.
// The whole chain of keyer phase changes for a tick is worked out combinationally.
// Synchronous reset puts the keyer in idle, key up, dit length 60, mode B.
// A two-entry output buffer takes results while the consumer stalls;
// in_stall rises only once both entries hold results.
module iambic_morse_keyer_top #(
  parameter int unsigned TIMER_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  iamk_pkg::iamk_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output iamk_pkg::iamk_out_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [iamk_pkg::ADDR_W-1:0]  paddr,
  input  logic [iamk_pkg::DATA_W-1:0]  pwdata,
  output logic [iamk_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import iamk_pkg::*;

  logic      in_valid_r;
  iamk_in_t  in_data_r;
  logic      buf_full;
  logic      adv;
  logic      in_xfer;
  iamk_cfg_t cfg;
  iamk_out_t result;

  assign adv      = in_valid_r & ~buf_full;
  assign in_stall = in_valid_r & buf_full;
  assign in_xfer  = in_valid & ~in_stall;

  // Input register: refilled in the same cycle that its tick moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_data_r <= in_data;
    end
  end

  iamk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iamk_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .contacts (in_data_r),
    .cfg      (cfg),
    .result   (result)
  );

  iamk_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/iamk_checker.sv
module iamk_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input iamk_pkg::iamk_out_t          out_data
);
  import iamk_pkg::*;

  // Reset leaves both channels empty and ready.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not clear after reset");

  // A stalled result stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Character fields read zero unless a character completes.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.char_ready |->
      out_data.char_ascii == 7'd0 && out_data.element_pattern == 8'd0)
    else $error("character fields set without a character");

  // A character completes only at the end of the gap, with the key up.
  a_char_key_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.char_ready |-> !out_data.key_level)
    else $error("character completed with key down");

endmodule

bind iambic_morse_keyer_top iamk_checker u_iamk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: test/tb_iambic_morse_keyer_top.sv
`timescale 1ns / 100ps

module tb_iambic_morse_keyer_top;
  import iamk_pkg::*;

  localparam int unsigned TIMER_BITS  = 12;
  localparam int unsigned TIMER_TOP   = (1 << TIMER_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;

  // Keyer steps of the predictor; the checking steps never persist across a tick.
  typedef enum logic [2:0] {
    KP_IDLE, KP_CHK_DIT, KP_CHK_DAH, KP_PREP, KP_KEYED, KP_GAP, KP_PRE_IDLE
  } keyer_step_t;

  logic clk;
  logic rst_n;

  logic      in_valid  = 1'b0;
  logic      in_stall;
  iamk_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  iamk_out_t out_data;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Register mirror used by the predictor.
  logic [10:0] cfg_dit;
  logic        cfg_swap;
  logic        cfg_mode_b;

  // Predictor state.
  keyer_step_t           k_phase;
  logic                  k_dit_latch;
  logic                  k_dah_latch;
  logic                  k_dit_run;
  logic                  k_key;
  logic [TIMER_BITS-1:0] k_count;
  logic [TIMER_BITS-1:0] k_limit;
  logic [7:0]            k_pattern;

  // Padded element pattern to character.
  logic [6:0] morse_char [256];

  iamk_in_t  paddle_ticks [$];
  iamk_out_t results_due [$];
  iamk_out_t due;

  int unsigned ticks_queued    = 0;
  int unsigned results_checked = 0;
  int unsigned chars_decoded   = 0;
  int unsigned key_down_ticks  = 0;
  int unsigned errors          = 0;
  int unsigned cycle_count     = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_fire        = 1'b0;
  logic        hold_armed     = 1'b0;
  logic        hold_used      = 1'b0;
  int unsigned hold_left      = 0;

  iambic_morse_keyer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The character table is built from dot-dash spellings, each shifted in
  // under the starting pad exactly as the keyer records elements.
  initial begin : morse_setup
    string      spec;
    logic [7:0] pat;
    logic [6:0] sym;
    bit         in_word;
    spec = {"A.- B-... C-.-. D-.. E. F..-. G--. H.... I.. J.--- K-.- L.-.. M-- ",
            "N-. O--- P.--. Q--.- R.-. S... T- U..- V...- W.-- X-..- Y-.-- Z--.. ",
            "0----- 1.---- 2..--- 3...-- 4....- 5..... 6-.... 7--... 8---.. 9----. ",
            "/-..-. ?..--.. *.-.-. #......."};
    for (int i = 0; i < 256; i++) morse_char[i] = ASCII_SPACE;
    in_word = 1'b0;
    for (int i = 0; i <= spec.len(); i++) begin
      if (i == spec.len() || spec[i] == " ") begin
        if (in_word) morse_char[pat] = sym;
        in_word = 1'b0;
      end else if (!in_word) begin
        sym     = spec[i][6:0];
        pat     = PATTERN_START;
        in_word = 1'b1;
      end else begin
        pat = {pat[6:0], spec[i] == "-"};
      end
    end
  end

  // Starts an interval; long spans are clipped so that the timer still expires.
  function automatic void arm_timer(int unsigned span);
    k_count = '0;
    k_limit = (span > TIMER_TOP - 1) ? TIMER_BITS'(TIMER_TOP - 1) : span[TIMER_BITS-1:0];
  endfunction

  // Advances the keyer by one tick and returns the result the block should give.
  function automatic iamk_out_t keyer_tick(iamk_in_t t);
    iamk_out_t r;
    logic      dit_pad;
    logic      dah_pad;
    logic      busy;
    r       = '0;
    dit_pad = cfg_swap ? t.right_contact : t.left_contact;
    dah_pad = cfg_swap ? t.left_contact : t.right_contact;
    if (k_count != TIMER_BITS'(TIMER_TOP)) k_count = k_count + 1'b1;
    busy = 1'b1;
    for (int n = 0; n < 16 && busy; n++) begin
      case (k_phase)
        KP_CHK_DIT: begin
          if (k_dit_latch) begin
            k_dit_run = 1'b1;
            arm_timer(cfg_dit);
            k_pattern = {k_pattern[6:0], 1'b0};
            k_phase   = KP_PREP;
          end else begin
            k_phase = KP_CHK_DAH;
          end
        end
        KP_CHK_DAH: begin
          if (k_dah_latch) begin
            arm_timer(3 * cfg_dit);
            k_pattern = {k_pattern[6:0], 1'b1};
            k_phase   = KP_PREP;
          end else begin
            arm_timer(2 * cfg_dit);
            k_phase = KP_PRE_IDLE;
          end
        end
        KP_PREP: begin
          k_key       = 1'b1;
          k_dit_latch = 1'b0;
          k_dah_latch = 1'b0;
          k_phase     = KP_KEYED;
          busy        = 1'b0;
        end
        KP_KEYED: begin
          if (k_count > k_limit) begin
            k_key = 1'b0;
            arm_timer(cfg_dit);
            k_phase = KP_GAP;
          end else begin
            // Iambic B remembers paddle presses made while the key is down.
            if (cfg_mode_b) begin
              k_dit_latch = k_dit_latch | dit_pad;
              k_dah_latch = k_dah_latch | dah_pad;
            end
            busy = 1'b0;
          end
        end
        KP_GAP: begin
          k_dit_latch = k_dit_latch | dit_pad;
          k_dah_latch = k_dah_latch | dah_pad;
          if (k_count > k_limit) begin
            if (k_dit_run) begin
              k_dit_latch = 1'b0;
              k_dit_run   = 1'b0;
              k_phase     = KP_CHK_DAH;
            end else begin
              k_dah_latch = 1'b0;
              arm_timer(2 * cfg_dit);
              k_phase = KP_PRE_IDLE;
            end
          end else begin
            busy = 1'b0;
          end
        end
        KP_PRE_IDLE: begin
          if (dit_pad || dah_pad || k_dit_latch || k_dah_latch) begin
            k_dit_latch = k_dit_latch | dit_pad;
            k_dah_latch = k_dah_latch | dah_pad;
            k_phase     = KP_CHK_DIT;
          end else if (k_count > k_limit) begin
            r.char_ready      = 1'b1;
            r.char_ascii      = morse_char[k_pattern];
            r.element_pattern = k_pattern;
            k_phase           = KP_IDLE;
          end else begin
            busy = 1'b0;
          end
        end
        default: begin
          if (dit_pad || dah_pad || k_dit_latch || k_dah_latch) begin
            k_dit_latch = k_dit_latch | dit_pad;
            k_dah_latch = k_dah_latch | dah_pad;
            k_pattern   = PATTERN_START;
            k_phase     = KP_CHK_DIT;
          end else begin
            k_phase = KP_IDLE;
            busy    = 1'b0;
          end
        end
      endcase
    end
    r.key_level = k_key;
    return r;
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // Sender: a new tick is offered only once the previous one has transferred.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (paddle_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= paddle_ticks.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off while it runs.
  always @(negedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // Long hold-off on the result side, counted here once armed.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Monitor: predicts on every input transfer and checks every result transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing expected, got %0h", $time, out_data);
          errors++;
        end else begin
          due = results_due.pop_front();
          check_field("key_level", 8'(due.key_level), 8'(out_data.key_level));
          check_field("char_ready", 8'(due.char_ready), 8'(out_data.char_ready));
          check_field("char_ascii", 8'(due.char_ascii), 8'(out_data.char_ascii));
          check_field("element_pattern", due.element_pattern, out_data.element_pattern);
          results_checked++;
          if (out_data.key_level === 1'b1) key_down_ticks++;
          if (out_data.char_ready === 1'b1) chars_decoded++;
        end
      end
      if (in_valid && !in_stall) results_due.push_back(keyer_tick(in_data));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d of %0d ticks checked",
               cycle_count, results_checked, ticks_queued);
      $display("TB_ERROR");
      $finish;
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(iamk_reg_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_DIT_TICKS:    cfg_dit    = value[10:0];
      REG_SWAP_PADDLES: cfg_swap   = value[0];
      REG_MODE_B:       cfg_mode_b = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_ticks(logic left, logic right, int unsigned n);
    iamk_in_t t;
    t.left_contact  = left;
    t.right_contact = right;
    repeat (n) paddle_ticks.push_back(t);
    ticks_queued += n;
  endtask

  // Mostly whole characters built from paddle presses, with a share of
  // contact noise; lengths scale with the current dit length.
  task automatic queue_keying(int unsigned n);
    int unsigned first;
    int unsigned d;
    int unsigned hold;
    logic [1:0]  lr;
    first = ticks_queued;
    d     = (cfg_dit == 0) ? 1 : cfg_dit;
    while (ticks_queued - first < n) begin
      if ($urandom_range(9) < 8) begin
        repeat ($urandom_range(8, 1)) begin
          hold = $urandom_range(3 * d + 1, 1);
          case ($urandom_range(6))
            0, 1: lr = 2'b10;
            2, 3: lr = 2'b01;
            4:    lr = 2'b11;
            5: begin
              // A long dit hold runs out the pattern register.
              lr   = cfg_swap ? 2'b01 : 2'b10;
              hold = 7 * (2 * d + 3);
            end
            default: lr = 2'($urandom_range(3));
          endcase
          queue_ticks(lr[1], lr[0], hold);
          queue_ticks(1'b0, 1'b0, $urandom_range(2 * d, 0));
        end
        queue_ticks(1'b0, 1'b0, $urandom_range(6 * d + 4, 3 * d + 1));
      end else begin
        repeat ($urandom_range(10, 1)) begin
          lr = 2'($urandom_range(3));
          queue_ticks(lr[1], lr[0], 1);
        end
      end
    end
  endtask

  // Returns once every queued tick has had its result checked.
  task automatic wait_drained();
    while (results_checked < ticks_queued) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned dit, logic swap, logic modeb, int unsigned send_pct,
                           int unsigned recv_pct, logic with_hold, int unsigned n);
    wait_drained();
    write_reg(REG_DIT_TICKS, dit);
    write_reg(REG_SWAP_PADDLES, 32'(swap));
    write_reg(REG_MODE_B, 32'(modeb));
    hold_armed = with_hold;
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_keying(n);
  endtask

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    cfg_dit     = DIT_TICKS_RESET;
    cfg_swap    = 1'b0;
    cfg_mode_b  = 1'b1;
    k_phase     = KP_IDLE;
    k_dit_latch = 1'b0;
    k_dah_latch = 1'b0;
    k_dit_run   = 1'b0;
    k_key       = 1'b0;
    k_count     = '0;
    k_limit     = '0;
    k_pattern   = PATTERN_START;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero dit length: every timer runs out on the following tick.
    write_reg(REG_DIT_TICKS, 0);
    write_reg(REG_SWAP_PADDLES, 0);
    write_reg(REG_MODE_B, 1);
    @(posedge clk);
    queue_ticks(1'b0, 1'b0, 1);
    queue_ticks(1'b1, 1'b0, 1);
    queue_ticks(1'b0, 1'b0, 5);
    queue_ticks(1'b0, 1'b1, 1);
    queue_ticks(1'b0, 1'b0, 5);
    queue_ticks(1'b1, 1'b1, 1);
    queue_ticks(1'b0, 1'b0, 6);

    // Swapped paddles in iambic A.
    wait_drained();
    write_reg(REG_SWAP_PADDLES, 1);
    write_reg(REG_MODE_B, 0);
    @(posedge clk);
    queue_ticks(1'b1, 1'b0, 1);
    queue_ticks(1'b0, 1'b1, 1);
    queue_ticks(1'b0, 1'b0, 3);

    // A long dit: one dah, its gap and the whole character gap.
    wait_drained();
    write_reg(REG_DIT_TICKS, 50);
    write_reg(REG_SWAP_PADDLES, 0);
    @(posedge clk);
    queue_ticks(1'b0, 1'b1, 1);
    queue_ticks(1'b0, 1'b0, 320);

    // Random keying under several settings and flow-control patterns.
    run_phase(1, 1'b0, 1'b1, 0, 0, 1'b0, 220);
    run_phase(2, 1'b1, 1'b0, 65, 0, 1'b0, 220);
    run_phase(3, 1'b0, 1'b0, 0, 65, 1'b0, 220);
    run_phase(1, 1'b1, 1'b1, 15, 15, 1'b0, 220);
    run_phase(4, 1'b0, 1'b1, 0, 0, 1'b1, 220);
    run_phase($urandom_range(6, 1), 1'($urandom_range(1)), 1'($urandom_range(1)),
              15, 15, 1'b0, 220);

    wait_drained();
    repeat (8) @(negedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, results_due.size());
      errors++;
    end

    $display("Checked %0d ticks at dit lengths 0 to 50, both paddle sides, iambic A and B,",
             results_checked);
    $display("with sender gaps, receiver stalls and a long hold-off: %0d characters, %0d key down",
             chars_decoded, key_down_ticks);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/iamk_pkg.sv
rtl/iamk_cfg.sv
rtl/iamk_core.sv
rtl/iamk_out_buf.sv
rtl/iambic_morse_keyer_top.sv
rtl/iamk_checker.sv
test/tb_iambic_morse_keyer_top.sv
